>>> rtl/core/polish_text_encoding_detector_defines.svh
// Assertion macros shared by the encoding detector RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef POLISH_TEXT_ENCODING_DETECTOR_DEFINES_SVH
`define POLISH_TEXT_ENCODING_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTED_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pted assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTED_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pted assertion failed");

`endif

>>> rtl/core/pted_pkg.sv
// Types, code points and lookup tables of the encoding detector.
// Depends on nothing; used by every module of the block.
package pted_pkg;

	localparam int LETTERS = 18;

	localparam logic [2:0] ENC_UNKNOWN = 3'd0;
	localparam logic [2:0] ENC_U8_BOM  = 3'd1;
	localparam logic [2:0] ENC_U8      = 3'd2;
	localparam logic [2:0] ENC_UTF16LE = 3'd3;
	localparam logic [2:0] ENC_CP1250  = 3'd4;
	localparam logic [2:0] ENC_LATIN2  = 3'd5;
	localparam logic [2:0] ENC_CP852   = 3'd6;

	localparam logic [7:0] BOM_0 = 8'hef;
	localparam logic [7:0] BOM_1 = 8'hbb;
	localparam logic [7:0] BOM_2 = 8'hbf;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] PRINT_LO = 8'h20;

	typedef logic [7:0] byte_tab_t [LETTERS];
	typedef logic [15:0] word_tab_t [LETTERS];

	localparam byte_tab_t TAB_CP1250 = '{
		8'hb9, 8'he6, 8'hea, 8'hb3, 8'hf1, 8'hf3, 8'h9c, 8'h9f, 8'hbf,
		8'ha5, 8'hc6, 8'hca, 8'ha3, 8'hd1, 8'hd3, 8'h8c, 8'h8f, 8'haf};
	localparam byte_tab_t TAB_ISO2 = '{
		8'hb1, 8'he6, 8'hea, 8'hb3, 8'hf1, 8'hf3, 8'hb6, 8'hbc, 8'hbf,
		8'ha1, 8'hc6, 8'hca, 8'ha3, 8'hd1, 8'hd3, 8'ha6, 8'hac, 8'haf};
	localparam byte_tab_t TAB_CP852 = '{
		8'ha5, 8'h86, 8'ha9, 8'h88, 8'he4, 8'ha2, 8'h98, 8'hab, 8'hbe,
		8'ha4, 8'h8f, 8'ha8, 8'h9d, 8'he3, 8'he0, 8'h97, 8'h8d, 8'hbd};
	// Lead byte in the low half, continuation byte in the high half.
	localparam word_tab_t TAB_UTF8 = '{
		16'h85c4, 16'h87c4, 16'h99c4, 16'h82c5, 16'h84c5, 16'hb3c3,
		16'h9bc5, 16'hbac5, 16'hbcc5, 16'h84c4, 16'h86c4, 16'h98c4,
		16'h81c5, 16'h83c5, 16'h93c3, 16'h9ac5, 16'hb9c5, 16'hbbc5};
	localparam word_tab_t TAB_WIDE = '{
		16'h0105, 16'h0107, 16'h0119, 16'h0142, 16'h0144, 16'h00f3,
		16'h015b, 16'h017a, 16'h017c, 16'h0104, 16'h0106, 16'h0118,
		16'h0141, 16'h0143, 16'h00d3, 16'h015a, 16'h0179, 16'h017b};

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last;
		logic       utf8_single;
		logic [2:0] sb_ok;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	function automatic logic in_bytes(input byte_tab_t tab, input logic [7:0] v);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < LETTERS; k++) begin
			hit = hit | (tab[k] == v);
		end
		return hit;
	endfunction

	function automatic logic in_words(input word_tab_t tab, input logic [15:0] v);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < LETTERS; k++) begin
			hit = hit | (tab[k] == v);
		end
		return hit;
	endfunction

	function automatic logic printable(input logic [7:0] v);
		return (v >= PRINT_LO) && !v[7];
	endfunction

endpackage

>>> rtl/core/polish_text_encoding_detector.sv
// Top level of the Polish text encoding detector.
// Depends on pted_pkg, pted_front, pted_fifo and pted_back.
//
//   channel  | direction | handshake    | payload
//   ---------+-----------+--------------+-------------------
//   input    | in        | push / full  | byte_value, last
//   result   | out       | empty / pop  | encoding
//
// One byte per cycle sustained unless a last byte waits on an untaken result;
// a last byte passes the front register, the queue and the result register,
// in that order, before its result is on the ports.
// The queue between front and back holds QUEUE_DEPTH bytes; the result
// register holds one answer, and bytes keep flowing while it waits unless
// the next last byte arrives. Reset clears all check state immediately.
module polish_text_encoding_detector #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] byte_value,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] encoding
);

	pted_pkg::fifo_status_t q_status;
	pted_pkg::item_t        wr_item;
	pted_pkg::item_t        rd_item;
	logic                   q_push;
	logic                   q_pop;

	pted_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.byte_value (byte_value),
		.last       (last),
		.q_status   (q_status),
		.q_push     (q_push),
		.q_item     (wr_item)
	);

	pted_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (wr_item),
		.rd_en   (q_pop),
		.rd_item (rd_item),
		.status  (q_status)
	);

	pted_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_item   (rd_item),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.encoding (encoding)
	);

endmodule

>>> rtl/core/pted_front.sv
// Input stage: takes bytes, classifies them against the code page tables.
// Depends on pted_pkg; feeds the queue in pted_fifo.
module pted_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            byte_value,
	input  logic                  last,
	input  pted_pkg::fifo_status_t q_status,
	output logic                  q_push,
	output pted_pkg::item_t       q_item
);

	logic            valid_s1;
	pted_pkg::item_t item_s1;
	pted_pkg::item_t item_c;
	logic            advance;
	logic            accept;
	logic            is_print;

	assign advance = valid_s1 && !q_status.full;
	assign full    = valid_s1 && q_status.full;
	assign accept  = push && !full;

	always_comb begin
		is_print            = pted_pkg::printable(byte_value);
		item_c.byte_value   = byte_value;
		item_c.last         = last;
		item_c.utf8_single  = is_print || (byte_value == pted_pkg::CHAR_LF) ||
			(byte_value == pted_pkg::CHAR_CR);
		item_c.sb_ok[0]     = is_print || pted_pkg::in_bytes(pted_pkg::TAB_CP1250, byte_value);
		item_c.sb_ok[1]     = is_print || pted_pkg::in_bytes(pted_pkg::TAB_ISO2, byte_value);
		item_c.sb_ok[2]     = is_print || pted_pkg::in_bytes(pted_pkg::TAB_CP852, byte_value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

	assign q_push = advance;
	assign q_item = item_s1;

endmodule

>>> rtl/core/pted_fifo.sv
// Short queue of classified bytes between the front and back stages.
// Depends on pted_pkg and the assertion macros header.
`include "polish_text_encoding_detector_defines.svh"
module pted_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  pted_pkg::item_t        wr_item,
	input  logic                   rd_en,
	output pted_pkg::item_t        rd_item,
	output pted_pkg::fifo_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pted_pkg::item_t  slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_item      = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	`PTED_ASSERT_SAME(a_no_write_when_full, wr_en, !status.full)
	`PTED_ASSERT_SAME(a_no_read_when_empty, rd_en, !status.empty)
	`PTED_ASSERT_SAME(a_count_bounded, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule

>>> rtl/core/pted_back.sv
// Back stage: runs the BOM, UTF-8, UTF-16LE and single-byte checks and
// holds the result register. Depends on pted_pkg and the macros header.
`include "polish_text_encoding_detector_defines.svh"
module pted_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pted_pkg::fifo_status_t q_status,
	input  pted_pkg::item_t        q_item,
	output logic                   q_pop,
	output logic                   empty,
	input  logic                   pop,
	output logic [2:0]             encoding
);

	logic [1:0] pos_q;
	logic       bom_q;
	logic       u8ok_q;
	logic       u8pend_q;
	logic [7:0] u8first_q;
	logic       wok_q;
	logic       wodd_q;
	logic [7:0] wlow_q;
	logic [2:0] sb_q;
	logic       out_valid_q;
	logic [2:0] enc_q;

	logic [7:0] b;
	logic       bom_n;
	logic       bom_flag;
	logic       u8ok_n;
	logic       u8pend_n;
	logic       wok_n;
	logic       wodd_n;
	logic [2:0] sb_n;
	logic       u8_final;
	logic       w_final;
	logic       wide_print;
	logic [2:0] enc_n;
	logic       out_take;
	logic       done;

	assign out_take = pop && out_valid_q;
	assign q_pop    = !q_status.empty && (!q_item.last || !out_valid_q || out_take);
	assign done     = q_pop && q_item.last;
	assign b        = q_item.byte_value;

	always_comb begin
		unique case (pos_q)
			2'd0:    bom_n = bom_q && (b == pted_pkg::BOM_0);
			2'd1:    bom_n = bom_q && (b == pted_pkg::BOM_1);
			2'd2:    bom_n = bom_q && (b == pted_pkg::BOM_2);
			default: bom_n = bom_q;
		endcase
		bom_flag = bom_n && pos_q[1];

		u8ok_n   = u8ok_q;
		u8pend_n = u8pend_q;
		if (u8pend_q) begin
			u8ok_n   = u8ok_q && pted_pkg::in_words(pted_pkg::TAB_UTF8, {b, u8first_q});
			u8pend_n = 1'b0;
		end else if (!q_item.utf8_single) begin
			u8pend_n = 1'b1;
		end

		wide_print = (b == 8'h00) && pted_pkg::printable(wlow_q);
		wok_n      = wok_q;
		wodd_n     = !wodd_q;
		if (wodd_q) begin
			wok_n = wok_q && (wide_print ||
				pted_pkg::in_words(pted_pkg::TAB_WIDE, {b, wlow_q}));
		end

		sb_n     = sb_q & q_item.sb_ok;
		u8_final = u8ok_n && !u8pend_n;
		w_final  = wok_n && !wodd_n;

		if (bom_flag) begin
			enc_n = pted_pkg::ENC_U8_BOM;
		end else if (u8_final) begin
			enc_n = pted_pkg::ENC_U8;
		end else if (w_final) begin
			enc_n = pted_pkg::ENC_UTF16LE;
		end else if (sb_n[0]) begin
			enc_n = pted_pkg::ENC_CP1250;
		end else if (sb_n[1]) begin
			enc_n = pted_pkg::ENC_LATIN2;
		end else if (sb_n[2]) begin
			enc_n = pted_pkg::ENC_CP852;
		end else begin
			enc_n = pted_pkg::ENC_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			bom_q       <= 1'b1;
			u8ok_q      <= 1'b1;
			u8pend_q    <= 1'b0;
			u8first_q   <= 8'h00;
			wok_q       <= 1'b1;
			wodd_q      <= 1'b0;
			wlow_q      <= 8'h00;
			sb_q        <= 3'b111;
			out_valid_q <= 1'b0;
		end else begin
			if (done) begin
				pos_q     <= 2'd0;
				bom_q     <= 1'b1;
				u8ok_q    <= 1'b1;
				u8pend_q  <= 1'b0;
				u8first_q <= 8'h00;
				wok_q     <= 1'b1;
				wodd_q    <= 1'b0;
				wlow_q    <= 8'h00;
				sb_q      <= 3'b111;
			end else if (q_pop) begin
				if (pos_q != 2'd3) begin
					pos_q <= pos_q + 2'd1;
				end
				bom_q    <= bom_n;
				u8ok_q   <= u8ok_n;
				u8pend_q <= u8pend_n;
				if (!u8pend_q && !q_item.utf8_single) begin
					u8first_q <= b;
				end
				wok_q  <= wok_n;
				wodd_q <= wodd_n;
				if (!wodd_q) begin
					wlow_q <= b;
				end
				sb_q <= sb_n;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			enc_q <= enc_n;
		end
	end

	assign empty    = !out_valid_q;
	assign encoding = enc_q;

	`PTED_ASSERT_SAME(a_no_result_overwrite, done && out_valid_q, out_take)
	`PTED_ASSERT_NEXT(a_result_after_last, done, out_valid_q)
	`PTED_ASSERT_NEXT(a_state_cleared, done, pos_q == 2'd0 && bom_q && sb_q == 3'b111)

endmodule

>>> tb/sv/polish_text_encoding_detector_tb.sv
// Self-checking testbench for polish_text_encoding_detector.
// Depends on pted_pkg and the detector RTL; a byte-by-byte predictor supplies expected results.
module polish_text_encoding_detector_tb;

	localparam logic [7:0] PRINT_HI = 8'h7f;
	localparam int RANDOM_ITEMS = 500;
	localparam int TAIL_ITEMS = 40;
	localparam int MAX_REPORTS = 10;
	localparam logic [7:0] BOM_SEQ [3] = '{pted_pkg::BOM_0, pted_pkg::BOM_1, pted_pkg::BOM_2};

	typedef enum int {
		KIND_BOM, KIND_UTF8, KIND_WIDE, KIND_CP1250, KIND_ISO2, KIND_CP852,
		KIND_NOISE, KIND_BROKEN
	} buffer_kind_t;

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} text_byte_t;

	typedef struct packed {
		logic [1:0] pos;
		logic       bom_ok;
		logic       utf8_ok;
		logic       utf8_wait;
		logic [7:0] utf8_lead;
		logic       wide_ok;
		logic       wide_hi;
		logic [7:0] wide_lo;
		logic [2:0] sb_ok;
	} scan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [7:0] byte_value = 8'h00;
	logic last = 1'b0;
	logic full;
	logic empty;
	logic [2:0] encoding;

	text_byte_t pending_bytes [$];
	logic [2:0] expected_enc [$];
	scan_t scan;
	logic tail = 1'b0;
	int queued = 0;
	int mismatches = 0;
	int send_gap = 0;
	int recv_gap = 0;

	polish_text_encoding_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.byte_value(byte_value),
		.last(last),
		.empty(empty),
		.pop(pop),
		.encoding(encoding)
	);

	always #5 clk = ~clk;

	function automatic scan_t scan_init();
		scan_t s;
		s = '0;
		s.bom_ok = 1'b1;
		s.utf8_ok = 1'b1;
		s.wide_ok = 1'b1;
		s.sb_ok = 3'b111;
		return s;
	endfunction

	function automatic logic is_text(input logic [15:0] v);
		return v >= {8'h00, pted_pkg::PRINT_LO} && v <= {8'h00, PRINT_HI};
	endfunction

	function automatic logic byte_listed(input pted_pkg::byte_tab_t tab, input logic [7:0] v);
		for (int k = 0; k < pted_pkg::LETTERS; k++) begin
			if (tab[k] == v)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic word_listed(input pted_pkg::word_tab_t tab, input logic [15:0] v);
		for (int k = 0; k < pted_pkg::LETTERS; k++) begin
			if (tab[k] == v)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic no_idling();
		return tail && pending_bytes.size() < TAIL_ITEMS;
	endfunction

	// Advances the predictor's scan state by one byte; a final byte yields the expected encoding.
	task automatic scan_byte(input logic [7:0] b, input logic fin);
		logic [1:0] p;
		logic bom;
		logic [15:0] w;
		logic [2:0] enc;
		p = scan.pos;
		if (p < 2'd3 && b != BOM_SEQ[p])
			scan.bom_ok = 1'b0;
		bom = scan.bom_ok && p >= 2'd2;
		if (p < 2'd3)
			scan.pos = p + 2'd1;
		if (scan.utf8_wait) begin
			w = {b, scan.utf8_lead};
			if (!word_listed(pted_pkg::TAB_UTF8, w))
				scan.utf8_ok = 1'b0;
			scan.utf8_wait = 1'b0;
		end else if (!(b == pted_pkg::CHAR_LF || b == pted_pkg::CHAR_CR ||
				is_text({8'h00, b}))) begin
			scan.utf8_lead = b;
			scan.utf8_wait = 1'b1;
		end
		if (scan.wide_hi) begin
			w = {b, scan.wide_lo};
			if (!is_text(w) && !word_listed(pted_pkg::TAB_WIDE, w))
				scan.wide_ok = 1'b0;
			scan.wide_hi = 1'b0;
		end else begin
			scan.wide_lo = b;
			scan.wide_hi = 1'b1;
		end
		if (!is_text({8'h00, b})) begin
			if (!byte_listed(pted_pkg::TAB_CP1250, b))
				scan.sb_ok[0] = 1'b0;
			if (!byte_listed(pted_pkg::TAB_ISO2, b))
				scan.sb_ok[1] = 1'b0;
			if (!byte_listed(pted_pkg::TAB_CP852, b))
				scan.sb_ok[2] = 1'b0;
		end
		if (fin) begin
			if (scan.utf8_wait)
				scan.utf8_ok = 1'b0;
			if (scan.wide_hi)
				scan.wide_ok = 1'b0;
			if (bom)
				enc = pted_pkg::ENC_U8_BOM;
			else if (scan.utf8_ok)
				enc = pted_pkg::ENC_U8;
			else if (scan.wide_ok)
				enc = pted_pkg::ENC_UTF16LE;
			else if (scan.sb_ok[0])
				enc = pted_pkg::ENC_CP1250;
			else if (scan.sb_ok[1])
				enc = pted_pkg::ENC_LATIN2;
			else if (scan.sb_ok[2])
				enc = pted_pkg::ENC_CP852;
			else
				enc = pted_pkg::ENC_UNKNOWN;
			expected_enc = {expected_enc, enc};
			scan = scan_init();
		end
	endtask

	task automatic note_mismatch(input string what, input logic [2:0] exp_enc,
			input logic [2:0] act_enc);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s: expected encoding %0d, got %0d", what, exp_enc, act_enc);
	endtask

	task automatic send(input logic [7:0] value, input logic fin);
		pending_bytes = {pending_bytes, text_byte_t'({value, fin})};
		queued++;
	endtask

	// Builds one buffer of the given kind with random content.
	task automatic queue_buffer(input buffer_kind_t kind);
		logic [7:0] chars [$];
		buffer_kind_t style;
		int n;
		int r;
		logic [15:0] w;
		style = kind == KIND_BROKEN ? buffer_kind_t'($urandom_range(0, 5)) : kind;
		n = $urandom_range(0, 9) == 0 ? $urandom_range(10, 24) : $urandom_range(1, 6);
		if (style == KIND_BOM) begin
			chars = {chars, pted_pkg::BOM_0};
			chars = {chars, pted_pkg::BOM_1};
			chars = {chars, pted_pkg::BOM_2};
		end
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			w = {8'h00, 8'($urandom_range(pted_pkg::PRINT_LO, PRINT_HI))};
			case (style)
				KIND_BOM, KIND_UTF8: begin
					if (r == 0)
						chars = {chars,
							$urandom_range(0, 1) ? pted_pkg::CHAR_CR : pted_pkg::CHAR_LF};
					else if (r < 4) begin
						w = pted_pkg::TAB_UTF8[$urandom_range(0, pted_pkg::LETTERS - 1)];
						chars = {chars, w[7:0]};
						chars = {chars, w[15:8]};
					end else
						chars = {chars, w[7:0]};
				end
				KIND_WIDE: begin
					if (r < 4)
						w = pted_pkg::TAB_WIDE[$urandom_range(0, pted_pkg::LETTERS - 1)];
					chars = {chars, w[7:0]};
					chars = {chars, w[15:8]};
				end
				KIND_CP1250:
					chars = {chars, r < 4 ?
						pted_pkg::TAB_CP1250[$urandom_range(0, pted_pkg::LETTERS - 1)] :
						w[7:0]};
				KIND_ISO2:
					chars = {chars, r < 4 ?
						pted_pkg::TAB_ISO2[$urandom_range(0, pted_pkg::LETTERS - 1)] :
						w[7:0]};
				KIND_CP852:
					chars = {chars, r < 4 ?
						pted_pkg::TAB_CP852[$urandom_range(0, pted_pkg::LETTERS - 1)] :
						w[7:0]};
				default:
					chars = {chars, 8'($urandom_range(0, 255))};
			endcase
		end
		if (kind == KIND_BROKEN) begin
			if ($urandom_range(0, 2) == 0 && chars.size() > 1)
				void'(chars.pop_back());
			else
				chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
		end
		for (int i = 0; i < chars.size(); i++)
			send(chars[i], i == chars.size() - 1);
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || push || expected_enc.size() != 0)
			@(negedge clk);
	endtask

	// Sender: one transfer per accepted byte, with random bursts of idle cycles.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_gap = 0;
		end else if (push && full) begin
			push <= 1'b1;
		end else begin
			if (push)
				scan_byte(byte_value, last);
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (pending_bytes.size() == 0) begin
				push <= 1'b0;
			end else if (!no_idling() && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 4);
				push <= 1'b0;
			end else begin
				{byte_value, last} <= pending_bytes.pop_front();
				push <= 1'b1;
			end
		end
	end

	// Receiver: checks each result transfer against the oldest expected encoding.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			recv_gap = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_enc.size() == 0)
					note_mismatch("unexpected result", pted_pkg::ENC_UNKNOWN, encoding);
				else if (encoding !== expected_enc[0])
					note_mismatch("wrong encoding", expected_enc.pop_front(), encoding);
				else
					void'(expected_enc.pop_front());
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else if (!no_idling() && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 4);
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	initial begin
		buffer_kind_t kind;
		int r;
		scan = scan_init();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send(8'h00, 1'b1);
		send(8'hff, 1'b1);
		send(pted_pkg::BOM_0, 1'b0);
		send(pted_pkg::BOM_1, 1'b0);
		send(pted_pkg::BOM_2, 1'b1);
		send(pted_pkg::BOM_0, 1'b0);
		send(pted_pkg::BOM_1, 1'b1);
		send(8'h41, 1'b1);
		send(8'hc4, 1'b0);
		send(8'h85, 1'b1);
		send(8'h05, 1'b0);
		send(8'h01, 1'b1);
		send(8'hc4, 1'b1);
		send(8'hb9, 1'b1);
		send(8'hb1, 1'b1);
		send(8'h86, 1'b1);
		send(pted_pkg::CHAR_CR, 1'b0);
		send(pted_pkg::CHAR_LF, 1'b1);
		send(pted_pkg::PRINT_LO, 1'b0);
		send(PRINT_HI, 1'b1);
		send(8'h41, 1'b0);
		send(8'h00, 1'b0);
		send(8'h41, 1'b1);
		wait_drained();

		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				kind = KIND_NOISE;
			else if (r == 1)
				kind = KIND_BROKEN;
			else
				kind = buffer_kind_t'($urandom_range(0, 5));
			queue_buffer(kind);
		end
		tail = 1'b1;
		wait_drained();
		repeat (20) @(posedge clk);

		while (expected_enc.size() != 0)
			note_mismatch("missing result", expected_enc.pop_front(), pted_pkg::ENC_UNKNOWN);
		if (mismatches == 0)
			$display("polish_text_encoding_detector: match");
		else
			$display("polish_text_encoding_detector: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("polish_text_encoding_detector: mismatch");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pted_pkg.sv
rtl/core/pted_front.sv
rtl/core/pted_fifo.sv
rtl/core/pted_back.sv
rtl/core/polish_text_encoding_detector.sv
tb/sv/polish_text_encoding_detector_tb.sv
